[hdl/tbpf_pkg.sv]
// Shared types and constants for the tile background pixel fetch unit.
// Used by the controller, the datapath and the top level. No dependencies.
package tbpf_pkg;

  // Video memory geometry (8 KB)
  localparam int unsigned VMEM_DEPTH = 8192;
  localparam int unsigned VMEM_AW    = 13;
  localparam int unsigned VMEM_DW    = 8;

  // Configuration port
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 32;

  localparam logic [7:0] CONTROL_RESET = 8'h91;

  // display_control bit positions
  localparam int unsigned CTL_DISPLAY_EN = 7;
  localparam int unsigned CTL_UNSIGNED   = 4;
  localparam int unsigned CTL_MAP_HIGH   = 3;

  typedef enum logic [CFG_IW-1:0] {
    CFG_DISPLAY_CONTROL = 3'd0,
    CFG_SCROLL_Y        = 3'd1,
    CFG_SCROLL_X        = 3'd2,
    CFG_PALETTE_0       = 3'd3,
    CFG_PALETTE_1       = 3'd4,
    CFG_PALETTE_2       = 3'd5,
    CFG_PALETTE_3       = 3'd6
  } cfg_index_e;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_RENDER = 1'b1
  } op_e;

  // Controller to datapath commands
  typedef struct packed {
    logic wr;         // write input byte to video memory
    logic acc;        // latch render coordinates, read tile map
    logic issue_lo;   // read low bit-plane byte
    logic issue_hi;   // read high bit-plane byte
    logic load_pix;   // load result register
  } tbpf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_render;
    logic on_screen;
  } tbpf_status_t;

endpackage

[hdl/tile_background_pixel_fetch_unit.sv]
// Channel   Dir  Handshake               Payload
// in        in   in_valid_i/in_ready_o   operation, vram_address, write_data, pixel_x, pixel_y
// out       out  out_valid_o/out_ready_i display_on, color_index, red, green, blue, alpha
// cfg       in   cfg_we_i                cfg_index_i, cfg_wdata_i
//
// A write beat is one video memory write. A render makes one read each of the single-port
// video memory for tile map, low plane and high plane; the result is registered after the
// last read, once the output slot is free. Off-screen renders give no result.
// Only control state and configuration registers are reset; video memory is not cleared.
// A held result stalls input once the next pixel finishes its last read.
// Top level of the tile background pixel fetch unit; depends on tbpf_pkg,
// tbpf_ctrl and tbpf_dp.
module tile_background_pixel_fetch_unit import tbpf_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 160,
  parameter int unsigned SCREEN_HEIGHT = 144
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [VMEM_AW-1:0] vram_address_i,
  input  logic [7:0]         write_data_i,
  input  logic [7:0]         pixel_x_i,
  input  logic [7:0]         pixel_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               display_on_o,
  output logic [1:0]         color_index_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [7:0]         alpha_o,
  input  logic               cfg_we_i,
  input  logic [CFG_IW-1:0]  cfg_index_i,
  input  logic [CFG_DW-1:0]  cfg_wdata_i
);

  tbpf_cmd_t    cmd;
  tbpf_status_t status;

  tbpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tbpf_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .operation_i    (operation_i),
    .vram_address_i (vram_address_i),
    .write_data_i   (write_data_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .display_on_o   (display_on_o),
    .color_index_o  (color_index_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o)
  );

endmodule

[hdl/tbpf_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module tbpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/tbpf_ctrl.sv]
// Sequencer for the pixel fetch: three dependent video memory reads per pixel.
// Depends on tbpf_pkg for the command and status structs.
module tbpf_ctrl import tbpf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  tbpf_status_t status_i,
  output tbpf_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TILE,
    S_LO,
    S_HI
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free, accept, render_go;

  // Result slot is free when empty or being drained this cycle;
  // idle takes a beat even while a result waits, the fetch holds in S_HI
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || (state_q == S_HI && out_free);
  assign accept     = in_valid_i && in_ready_o;
  assign render_go  = accept && status_i.is_render && status_i.on_screen;

  // Commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.wr       = accept && !status_i.is_render;
    cmd_o.acc      = render_go;
    cmd_o.issue_lo = (state_q == S_TILE);
    cmd_o.issue_hi = (state_q == S_LO);
    cmd_o.load_pix = (state_q == S_HI) && out_free;
  end

  // Next state
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (render_go) begin
          state_d = S_TILE;
        end
      end
      S_TILE: state_d = S_LO;
      S_LO:   state_d = S_HI;
      S_HI: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = render_go ? S_TILE : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Single memory port: at most one access per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.wr, cmd_o.acc, cmd_o.issue_lo, cmd_o.issue_hi}))
    else $error("tbpf_ctrl: video memory port conflict");

  // An accepted on-screen render starts the fetch sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    render_go |=> state_q == S_TILE)
    else $error("tbpf_ctrl: render not started");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TILE |=> state_q == S_LO)
    else $error("tbpf_ctrl: tile read not followed by plane read");

  // Finishing a pixel with a free slot always presents a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HI && !out_valid_q) |=> out_valid_q)
    else $error("tbpf_ctrl: finished pixel lost");

endmodule

[hdl/tbpf_dp.sv]
// Datapath: configuration registers, address forming, video memory, result register.
// Depends on tbpf_pkg and tbpf_ram.
module tbpf_dp import tbpf_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 160,
  parameter int unsigned SCREEN_HEIGHT = 144
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                operation_i,
  input  logic [VMEM_AW-1:0]  vram_address_i,
  input  logic [7:0]          write_data_i,
  input  logic [7:0]          pixel_x_i,
  input  logic [7:0]          pixel_y_i,
  input  logic                cfg_we_i,
  input  logic [CFG_IW-1:0]   cfg_index_i,
  input  logic [CFG_DW-1:0]   cfg_wdata_i,
  input  tbpf_cmd_t           cmd_i,
  output tbpf_status_t        status_o,
  output logic                display_on_o,
  output logic [1:0]          color_index_o,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o,
  output logic [7:0]          alpha_o
);

  logic [7:0]         control_q;
  logic [7:0]         scroll_y_q;
  logic [7:0]         scroll_x_q;
  logic [31:0]        palette_q [4];

  logic [2:0]         row_lo_q, col_lo_q;
  logic [VMEM_AW-1:0] line_q;
  logic [7:0]         lo_q;

  logic [7:0]         row, col;
  logic [VMEM_AW-1:0] map_addr, line_lo, line_hi, ram_addr;
  logic [7:0]         rdata;
  logic               ram_en;
  logic [2:0]         bit_sel;
  logic [1:0]         ci;
  logic [31:0]        rgba;

  logic               display_on_q;
  logic [1:0]         color_index_q;
  logic [31:0]        rgba_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q    <= CONTROL_RESET;
      scroll_y_q   <= '0;
      scroll_x_q   <= '0;
      palette_q[0] <= '0;
      palette_q[1] <= '0;
      palette_q[2] <= '0;
      palette_q[3] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_DISPLAY_CONTROL: control_q    <= cfg_wdata_i[7:0];
        CFG_SCROLL_Y:        scroll_y_q   <= cfg_wdata_i[7:0];
        CFG_SCROLL_X:        scroll_x_q   <= cfg_wdata_i[7:0];
        CFG_PALETTE_0:       palette_q[0] <= cfg_wdata_i;
        CFG_PALETTE_1:       palette_q[1] <= cfg_wdata_i;
        CFG_PALETTE_2:       palette_q[2] <= cfg_wdata_i;
        CFG_PALETTE_3:       palette_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Status to the controller
  assign status_o.is_render = (op_e'(operation_i) == OP_RENDER);
  assign status_o.on_screen = ({1'b0, pixel_x_i} < 9'(SCREEN_WIDTH)) &&
                              ({1'b0, pixel_y_i} < 9'(SCREEN_HEIGHT));

  // Scrolled coordinates, wrap at 256
  assign row = pixel_y_i + scroll_y_q;
  assign col = pixel_x_i + scroll_x_q;

  // Tile map entry: 0x1800 or 0x1C00 + row/8 * 32 + col/8
  assign map_addr = {2'b11, control_q[CTL_MAP_HIGH], row[7:3], col[7:3]};

  // Tile row address; signed mode puts tiles 0..127 at 0x1000, 128..255 at 0x0800
  assign line_lo = {~control_q[CTL_UNSIGNED] & ~rdata[7], rdata, row_lo_q, 1'b0};
  assign line_hi = {line_q[VMEM_AW-1:1], 1'b1};

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      row_lo_q <= row[2:0];
      col_lo_q <= col[2:0];
    end
    if (cmd_i.issue_lo) begin
      line_q <= line_lo;
    end
    if (cmd_i.issue_hi) begin
      lo_q <= rdata;
    end
  end

  // Memory port select
  always_comb begin
    ram_addr = line_hi;
    if (cmd_i.wr) begin
      ram_addr = vram_address_i;
    end else if (cmd_i.acc) begin
      ram_addr = map_addr;
    end else if (cmd_i.issue_lo) begin
      ram_addr = line_lo;
    end
  end

  assign ram_en = cmd_i.wr || cmd_i.acc || cmd_i.issue_lo || cmd_i.issue_hi;

  tbpf_ram #(
    .WIDTH (VMEM_DW),
    .DEPTH (VMEM_DEPTH)
  ) u_vram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (cmd_i.wr),
    .addr_i  (ram_addr),
    .wdata_i (write_data_i),
    .rdata_o (rdata)
  );

  // Pixel bit: leftmost column is bit 7; high plane byte is on the read port
  assign bit_sel = ~col_lo_q;
  assign ci      = {rdata[bit_sel], lo_q[bit_sel]};
  assign rgba    = palette_q[ci];

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pix) begin
      display_on_q <= control_q[CTL_DISPLAY_EN];
      if (control_q[CTL_DISPLAY_EN]) begin
        color_index_q <= ci;
        rgba_q        <= rgba;
      end else begin
        color_index_q <= '0;
        rgba_q        <= '0;
      end
    end
  end

  assign display_on_o  = display_on_q;
  assign color_index_o = color_index_q;
  assign red_o         = rgba_q[31:24];
  assign green_o       = rgba_q[23:16];
  assign blue_o        = rgba_q[15:8];
  assign alpha_o       = rgba_q[7:0];

endmodule

[dv/tbpf_checker.sv]
// Scoreboard for the tile background pixel fetch unit: snoops the input, output and
// register ports, predicts each rendered pixel and compares the output beats.
// Depends on tbpf_pkg.
`timescale 1ns / 1ps

module tbpf_checker import tbpf_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 160,
  parameter int unsigned SCREEN_HEIGHT = 144
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  logic               operation_i,
  input  logic [VMEM_AW-1:0] vram_address_i,
  input  logic [7:0]         write_data_i,
  input  logic [7:0]         pixel_x_i,
  input  logic [7:0]         pixel_y_i,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic               display_on_o,
  input  logic [1:0]         color_index_o,
  input  logic [7:0]         red_o,
  input  logic [7:0]         green_o,
  input  logic [7:0]         blue_o,
  input  logic [7:0]         alpha_o,
  input  logic               cfg_we_i,
  input  logic [CFG_IW-1:0]  cfg_index_i,
  input  logic [CFG_DW-1:0]  cfg_wdata_i,
  output int                 err_cnt_o,
  output int                 pending_o
);

  // Offsets inside the 8 KB video memory
  localparam logic [VMEM_AW-1:0] MAP_LOW_BASE     = 13'h1800;
  localparam logic [VMEM_AW-1:0] MAP_HIGH_BASE    = 13'h1C00;
  localparam logic [VMEM_AW-1:0] SIGNED_DATA_BASE = 13'h1000;

  typedef struct packed {
    logic       display_on;
    logic [1:0] color_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  // Shadow copy of the block's state
  logic [7:0]  vram_q [VMEM_DEPTH];
  logic [7:0]  ctl_q      = CONTROL_RESET;
  logic [7:0]  scroll_y_q = '0;
  logic [7:0]  scroll_x_q = '0;
  logic [31:0] palette_q [4] = '{default: '0};

  pixel_t pixel_q [$];
  pixel_t want;
  int     n_errors = 0;

  assign err_cnt_o = n_errors;
  initial pending_o = 0;

  // Background fetch of one on-screen pixel under the current settings
  function automatic pixel_t fetch_pixel(logic [7:0] px, logic [7:0] py);
    pixel_t             pix;
    logic [7:0]         row, col, tile, lo, hi;
    logic [VMEM_AW-1:0] map_addr, tile_base, line;
    logic [2:0]         sh;
    logic [31:0]        rgba;
    pix = '0;
    if (ctl_q[CTL_DISPLAY_EN]) begin
      row      = py + scroll_y_q;
      col      = px + scroll_x_q;
      map_addr = (ctl_q[CTL_MAP_HIGH] ? MAP_HIGH_BASE : MAP_LOW_BASE) + {row[7:3], col[7:3]};
      tile     = vram_q[map_addr];
      // unsigned: index * 16; signed: base + sign-extended index * 16, wraps in 8 KB
      if (ctl_q[CTL_UNSIGNED]) tile_base = {1'b0, tile, 4'b0000};
      else                     tile_base = SIGNED_DATA_BASE + {tile[7], tile, 4'b0000};
      line = tile_base + {row[2:0], 1'b0};
      lo   = vram_q[line];
      hi   = vram_q[line + 1'b1];
      sh   = 3'd7 - col[2:0];  // leftmost pixel is bit 7
      pix.color_index = {hi[sh], lo[sh]};
      rgba            = palette_q[pix.color_index];
      pix.display_on  = 1'b1;
      pix.red         = rgba[31:24];
      pix.green       = rgba[23:16];
      pix.blue        = rgba[15:8];
      pix.alpha       = rgba[7:0];
    end
    return pix;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // output beat against the oldest predicted pixel
      if (out_valid_o && out_ready_i) begin
        if (pixel_q.size() == 0) begin
          $error("output beat with no pixel predicted");
          n_errors++;
        end else begin
          want = pixel_q.pop_front();
          check_field("display_on", 32'(want.display_on), 32'(display_on_o));
          check_field("color_index", 32'(want.color_index), 32'(color_index_o));
          check_field("red", 32'(want.red), 32'(red_o));
          check_field("green", 32'(want.green), 32'(green_o));
          check_field("blue", 32'(want.blue), 32'(blue_o));
          check_field("alpha", 32'(want.alpha), 32'(alpha_o));
        end
      end
      // input beat: memory write or render
      if (in_valid_i && in_ready_o) begin
        if (op_e'(operation_i) == OP_WRITE) begin
          vram_q[vram_address_i] = write_data_i;
        end else if (pixel_x_i < SCREEN_WIDTH && pixel_y_i < SCREEN_HEIGHT) begin
          pixel_q.push_back(fetch_pixel(pixel_x_i, pixel_y_i));
        end
      end
      // register writes; unknown index is dropped
      if (cfg_we_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_DISPLAY_CONTROL: ctl_q = cfg_wdata_i[7:0];
          CFG_SCROLL_Y:        scroll_y_q = cfg_wdata_i[7:0];
          CFG_SCROLL_X:        scroll_x_q = cfg_wdata_i[7:0];
          CFG_PALETTE_0:       palette_q[0] = cfg_wdata_i;
          CFG_PALETTE_1:       palette_q[1] = cfg_wdata_i;
          CFG_PALETTE_2:       palette_q[2] = cfg_wdata_i;
          CFG_PALETTE_3:       palette_q[3] = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o <= pixel_q.size();
    end
  end

endmodule

[dv/tb.sv]
// Testbench top for the tile background pixel fetch unit: clock, reset, register
// programming, beat stimulus with random bursts and output back-pressure.
// Depends on tbpf_pkg, tile_background_pixel_fetch_unit and tbpf_checker.
`timescale 1ns / 1ps

module tb;
  import tbpf_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 4;
  localparam int DRAIN_CYCLES = 12;
  localparam int LONG_HOLD    = 300;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 24;
  localparam int LIMIT_CYCLES = 500_000;

  localparam int unsigned SCREEN_WIDTH  = 160;
  localparam int unsigned SCREEN_HEIGHT = 144;

  // Offsets inside the 8 KB video memory
  localparam logic [VMEM_AW-1:0] MAP_LOW_BASE     = 13'h1800;
  localparam logic [VMEM_AW-1:0] MAP_HIGH_BASE    = 13'h1C00;
  localparam logic [VMEM_AW-1:0] SIGNED_DATA_BASE = 13'h1000;

  // register index the block does not implement
  localparam logic [CFG_IW-1:0] CFG_UNUSED = 3'd7;

  typedef enum int {RX_FREE, RX_HALF, RX_SPARSE} rx_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               operation_i;
  logic [VMEM_AW-1:0] vram_address_i;
  logic [7:0]         write_data_i;
  logic [7:0]         pixel_x_i;
  logic [7:0]         pixel_y_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               display_on_o;
  logic [1:0]         color_index_o;
  logic [7:0]         red_o;
  logic [7:0]         green_o;
  logic [7:0]         blue_o;
  logic [7:0]         alpha_o;
  logic               cfg_we_i;
  logic [CFG_IW-1:0]  cfg_index_i;
  logic [CFG_DW-1:0]  cfg_wdata_i;

  int err_cnt;
  int pending;
  int burst_left  = 0;
  int cycle_cnt   = 0;
  bit hold_req    = 0;
  bit hold_served = 0;
  int kind;

  // Stimulus-side view of memory contents and settings, so renders only
  // read bytes that were written
  logic [7:0] vram_shadow [VMEM_DEPTH];
  bit         vram_known  [VMEM_DEPTH];
  logic [7:0] cur_ctl = CONTROL_RESET;
  logic [7:0] cur_sy  = '0;
  logic [7:0] cur_sx  = '0;

  tile_background_pixel_fetch_unit #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_top (.*);

  tbpf_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_checker (
    .err_cnt_o (err_cnt),
    .pending_o (pending),
    .*
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output back-pressure: random segments, one long hold-off on request
  initial begin
    rx_mode_e mode;
    int       seg_len;
    out_ready_i = 1'b0;
    forever begin
      if (hold_req && !hold_served) begin
        hold_served = 1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        mode    = rx_mode_e'($urandom_range(0, 2));
        seg_len = $urandom_range(1, 40);
        repeat (seg_len) begin
          case (mode)
            RX_FREE: out_ready_i <= 1'b1;
            RX_HALF: out_ready_i <= 1'($urandom_range(0, 1));
            default: out_ready_i <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // One input beat; opens a new burst after a random gap when the old one ran out
  task automatic send_beat(op_e op, logic [VMEM_AW-1:0] addr, logic [7:0] data,
                           logic [7:0] px, logic [7:0] py);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    vram_address_i <= addr;
    write_data_i   <= data;
    pixel_x_i      <= px;
    pixel_y_i      <= py;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
  endtask

  task automatic vram_write(logic [VMEM_AW-1:0] addr, logic [7:0] data);
    vram_shadow[addr] = data;
    vram_known[addr]  = 1'b1;
    send_beat(OP_WRITE, addr, data, 8'($urandom), 8'($urandom));
  endtask

  // Write a byte only if it was never written
  task automatic vram_cover(logic [VMEM_AW-1:0] addr, logic [7:0] data);
    if (!vram_known[addr]) vram_write(addr, data);
  endtask

  // Render one pixel; first fill in any tile map or tile row byte it reads
  task automatic render(logic [7:0] px, logic [7:0] py);
    logic [7:0]         row, col, tile;
    logic [VMEM_AW-1:0] map_addr, tile_base, line;
    if (cur_ctl[CTL_DISPLAY_EN] && px < SCREEN_WIDTH && py < SCREEN_HEIGHT) begin
      row      = py + cur_sy;
      col      = px + cur_sx;
      map_addr = (cur_ctl[CTL_MAP_HIGH] ? MAP_HIGH_BASE : MAP_LOW_BASE) +
                 {3'b000, row[7:3], col[7:3]};
      // small pool of tile indexes so tile rows get reused
      vram_cover(map_addr, 8'($urandom) & 8'hC3);
      tile = vram_shadow[map_addr];
      if (cur_ctl[CTL_UNSIGNED]) tile_base = {1'b0, tile, 4'b0000};
      else                       tile_base = SIGNED_DATA_BASE + {tile[7], tile, 4'b0000};
      line = tile_base + {9'd0, row[2:0], 1'b0};
      vram_cover(line, 8'($urandom));
      vram_cover(line + 13'd1, 8'($urandom));
    end
    send_beat(OP_RENDER, 13'($urandom), 8'($urandom), px, py);
  endtask

  // Stop sending and wait until every predicted pixel is out and the pipe is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Program every register while idle; upper bits of 8-bit registers get junk
  task automatic set_regs(logic [7:0] ctl, logic [7:0] sy, logic [7:0] sx,
                          logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                          logic [31:0] c3);
    settle();
    if ($urandom_range(0, 2) == 0) cfg_write(CFG_UNUSED, $urandom);
    cfg_write(CFG_DISPLAY_CONTROL, ($urandom & 32'hFFFF_FF00) | {24'd0, ctl});
    cfg_write(CFG_SCROLL_Y, ($urandom & 32'hFFFF_FF00) | {24'd0, sy});
    cfg_write(CFG_SCROLL_X, ($urandom & 32'hFFFF_FF00) | {24'd0, sx});
    cfg_write(CFG_PALETTE_0, c0);
    cfg_write(CFG_PALETTE_1, c1);
    cfg_write(CFG_PALETTE_2, c2);
    cfg_write(CFG_PALETTE_3, c3);
    cfg_we_i <= 1'b0;
    cur_ctl = ctl;
    cur_sy  = sy;
    cur_sx  = sx;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_scroll();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_color();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [7:0] ctl;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    operation_i    = 1'b0;
    vram_address_i = '0;
    write_data_i   = '0;
    pixel_x_i      = '0;
    pixel_y_i      = '0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_wdata_i    = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_regs(CONTROL_RESET, 8'h00, 8'h00, $urandom, $urandom, $urandom, $urandom);

    // unsigned addressing, low map: bit order inside a tile row, screen edges
    vram_write(13'h1800, 8'h01);
    vram_write(13'h0010, 8'h80);
    vram_write(13'h0011, 8'h01);
    render(0, 0);
    render(7, 0);
    render(8, 0);
    render(8'(SCREEN_WIDTH - 1), 8'(SCREEN_HEIGHT - 1));
    render(8'(SCREEN_WIDTH), 0);
    render(0, 8'(SCREEN_HEIGHT));
    render(8'hFF, 8'hFF);
    vram_write(13'h1FFF, 8'hFF);

    // signed addressing, negative and positive tile index
    set_regs(8'h80, 8'h00, 8'h00, 32'h0, 32'hFFFF_FFFF, $urandom, $urandom);
    vram_write(13'h1800, 8'h80);
    render(0, 0);
    vram_write(13'h1800, 8'h7F);
    render(3, 0);

    // upper map with scroll wrapping past 255
    set_regs(8'h88, 8'hFF, 8'hFF, $urandom, $urandom, $urandom, $urandom);
    render(1, 1);
    render(0, 0);

    // display off: zero results, off-screen still dropped
    set_regs(8'h00, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF);
    render(10, 10);
    render(8'(SCREEN_WIDTH - 1), 8'(SCREEN_HEIGHT - 1));
    render(200, 0);

    // every control bit set
    set_regs(8'hFF, 8'hFF, 8'h00, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
    render(8'(SCREEN_WIDTH - 1), 8'(SCREEN_HEIGHT - 1));
    render(0, 0);

    // random phases: mostly on-screen renders, some writes and off-screen items
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0:       ctl = 8'h00;
        1:       ctl = 8'hFF;
        2:       ctl = 8'($urandom);
        default: ctl = 8'($urandom) | 8'h80;
      endcase
      set_regs(ctl, pick_scroll(), pick_scroll(), pick_color(), pick_color(),
               pick_color(), pick_color());
      // long hold-off starts before this phase's beats are offered
      if (ph == 2) begin
        hold_req = 1;
        wait (hold_served);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
          vram_write(13'($urandom), 8'($urandom));
        end else if (kind < 30) begin
          if ($urandom_range(0, 1)) begin
            render(8'($urandom_range(SCREEN_WIDTH, 255)), 8'($urandom));
          end else begin
            render(8'($urandom), 8'($urandom_range(SCREEN_HEIGHT, 255)));
          end
        end else begin
          render(8'($urandom_range(0, SCREEN_WIDTH - 1)),
                 8'($urandom_range(0, SCREEN_HEIGHT - 1)));
        end
      end
    end

    settle();
    if (err_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
hdl/tbpf_pkg.sv
hdl/tbpf_ram.sv
hdl/tbpf_ctrl.sv
hdl/tbpf_dp.sv
hdl/tile_background_pixel_fetch_unit.sv
dv/tbpf_checker.sv
dv/tb.sv
